### rtl/json_byte_tokenizer_core_defines.svh
// ----------------------------------------------------------------------------
// JSON byte tokenizer assertion macros
// Concurrent check helpers shared by the tokenizer RTL.
// ----------------------------------------------------------------------------
`ifndef JSON_BYTE_TOKENIZER_CORE_DEFINES_SVH
`define JSON_BYTE_TOKENIZER_CORE_DEFINES_SVH

// Check clocked on clk_i, switched off while reset is asserted
`define JBT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check clocked on clk_i that also holds during reset
`define JBT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

### rtl/jbt_pkg.sv
// ----------------------------------------------------------------------------
// JSON byte tokenizer package
// Lexer mode, number phase, token kind and error codes, character helpers.
// ----------------------------------------------------------------------------
package jbt_pkg;

  // Lexer modes
  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_STRING  = 3'd1;
  localparam logic [2:0] MODE_HEX     = 3'd2;
  localparam logic [2:0] MODE_NUMBER  = 3'd3;
  localparam logic [2:0] MODE_KEYWORD = 3'd4;

  // Number sub-states
  localparam logic [2:0] PH_SIGN    = 3'd0;
  localparam logic [2:0] PH_INT     = 3'd1;
  localparam logic [2:0] PH_POINT   = 3'd2;
  localparam logic [2:0] PH_FRAC    = 3'd3;
  localparam logic [2:0] PH_EXP     = 3'd4;
  localparam logic [2:0] PH_EXPSIGN = 3'd5;
  localparam logic [2:0] PH_EXPDIG  = 3'd6;

  // Token kinds
  localparam logic [3:0] KIND_LBRACE = 4'd0;
  localparam logic [3:0] KIND_RBRACE = 4'd1;
  localparam logic [3:0] KIND_LBRACK = 4'd2;
  localparam logic [3:0] KIND_RBRACK = 4'd3;
  localparam logic [3:0] KIND_COLON  = 4'd4;
  localparam logic [3:0] KIND_COMMA  = 4'd5;
  localparam logic [3:0] KIND_STRING = 4'd6;
  localparam logic [3:0] KIND_NUMBER = 4'd7;
  localparam logic [3:0] KIND_BOOL   = 4'd8;
  localparam logic [3:0] KIND_NULL   = 4'd9;
  localparam logic [3:0] KIND_END    = 4'd10;

  // Error codes
  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_NUMBER   = 3'd1;
  localparam logic [2:0] ERR_KEYWORD  = 3'd2;
  localparam logic [2:0] ERR_ESCAPE   = 3'd3;
  localparam logic [2:0] ERR_HEX      = 3'd4;
  localparam logic [2:0] ERR_START    = 3'd5;
  localparam logic [2:0] ERR_UNTERM   = 3'd6;
  localparam logic [2:0] ERR_DANGLING = 3'd7;

  // Keyword selectors
  localparam logic [1:0] KW_TRUE  = 2'd0;
  localparam logic [1:0] KW_FALSE = 2'd1;
  localparam logic [1:0] KW_NULL  = 2'd2;

  localparam logic [2:0] HEX_DIGITS = 3'd4;

  function automatic logic is_space(logic [7:0] c);
    return (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_hex(logic [7:0] c);
    return is_digit(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

  // Structural character: bit 4 set when c is one, low bits give the kind
  function automatic logic [4:0] struct_kind(logic [7:0] c);
    logic [4:0] r;
    case (c)
      "{":     r = {1'b1, KIND_LBRACE};
      "}":     r = {1'b1, KIND_RBRACE};
      "[":     r = {1'b1, KIND_LBRACK};
      "]":     r = {1'b1, KIND_RBRACK};
      ":":     r = {1'b1, KIND_COLON};
      ",":     r = {1'b1, KIND_COMMA};
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  function automatic logic [2:0] kw_len(logic [1:0] w);
    return (w == KW_FALSE) ? 3'd5 : 3'd4;
  endfunction

  // Keyword spelling; selector three aliases null
  function automatic logic [7:0] kw_char(logic [1:0] w, logic [2:0] idx);
    logic [7:0] r;
    r = 8'd0;
    case (w)
      KW_TRUE: begin
        case (idx)
          3'd0:    r = "t";
          3'd1:    r = "r";
          3'd2:    r = "u";
          3'd3:    r = "e";
          default: r = 8'd0;
        endcase
      end
      KW_FALSE: begin
        case (idx)
          3'd0:    r = "f";
          3'd1:    r = "a";
          3'd2:    r = "l";
          3'd3:    r = "s";
          3'd4:    r = "e";
          default: r = 8'd0;
        endcase
      end
      default: begin
        case (idx)
          3'd0:    r = "n";
          3'd1:    r = "u";
          3'd2:    r = "l";
          3'd3:    r = "l";
          default: r = 8'd0;
        endcase
      end
    endcase
    return r;
  endfunction

  function automatic logic [3:0] kw_kind(logic [1:0] w);
    return (w < 2'd2) ? KIND_BOOL : KIND_NULL;
  endfunction

  function automatic logic number_complete(logic [2:0] p);
    return (p == PH_INT) || (p == PH_FRAC) || (p == PH_EXPDIG);
  endfunction

endpackage

### rtl/json_byte_tokenizer_core.sv
// ----------------------------------------------------------------------------
// JSON byte tokenizer core
// Splits a JSON byte stream into tokens: value bytes plus a token-end record.
// ----------------------------------------------------------------------------
//
//  channel  | dir | tdata                                   | tuser        | tlast
//  ---------+-----+-----------------------------------------+--------------+----------
//  s_axis   | in  | text_byte                               | -            | last byte
//  m_axis   | out | content_byte, start_line, start_column, | token_kind,  | token_end
//           |     | error_code                              | content_valid|
//
//  One byte is taken per cycle; the lexer state updates in that cycle and its
//  zero to two records land in a four-entry output queue.
//  Records leave at one per cycle while m_axis_tready_i is high; bytes giving two
//  records (escapes, structural delimiter after a number) queue both at once.
//  Input is taken while the queue has room for two records.
//  Reset (async, active low) empties the queue and returns to line 1, column 1.
//
`include "json_byte_tokenizer_core_defines.svh"

module json_byte_tokenizer_core
  import jbt_pkg::*;
#(
  parameter int LINE_BITS   = 20,
  parameter int COLUMN_BITS = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // text_byte [7:0]
  input  logic [7:0] s_axis_tdata_i,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic       s_axis_tlast_i,
  // content_byte, start_line, start_column, error_code (lowest first)
  output logic [((8 + LINE_BITS + COLUMN_BITS + 3 + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // token_kind [3:0], content_valid [4]
  output logic [4:0] m_axis_tuser_o,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic       m_axis_tlast_o
);

  localparam int OUT_W = ((8 + LINE_BITS + COLUMN_BITS + 3 + 7) / 8) * 8;
  localparam int DEPTH = 4;

  localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
  localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;
  localparam logic [LINE_BITS-1:0]   LINE_ONE = LINE_BITS'(1);
  localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

  typedef struct packed {
    logic [3:0]             kind;
    logic                   cv;
    logic [7:0]             cbyte;
    logic                   te;
    logic [LINE_BITS-1:0]   line;
    logic [COLUMN_BITS-1:0] col;
    logic [2:0]             err;
  } rec_t;

  function automatic rec_t mk_rec(logic [3:0] kind, logic cv, logic [7:0] cb, logic te,
                                  logic [LINE_BITS-1:0] line, logic [COLUMN_BITS-1:0] col,
                                  logic [2:0] err);
    rec_t r;
    r.kind  = kind;
    r.cv    = cv;
    r.cbyte = cv ? cb : 8'd0;
    r.te    = te;
    r.line  = line;
    r.col   = col;
    r.err   = err;
    return r;
  endfunction

  // Lexer state
  logic [2:0]             mode_q, mode_d;
  logic [2:0]             phase_q, phase_d;
  logic [1:0]             which_q, which_d;
  logic [2:0]             kidx_q, kidx_d;
  logic                   esc_q, esc_d;
  logic [2:0]             hex_q, hex_d;
  logic [LINE_BITS-1:0]   cur_line_q, cur_line_d;
  logic [COLUMN_BITS-1:0] cur_col_q, cur_col_d;
  logic [LINE_BITS-1:0]   tok_line_q, tok_line_d;
  logic [COLUMN_BITS-1:0] tok_col_q, tok_col_d;

  // Output queue
  rec_t       q_q [DEPTH];
  rec_t       q_d [DEPTH];
  logic [2:0] cnt_q, cnt_d;

  rec_t [1:0] rec;
  logic [1:0] n_rec;

  logic [7:0] c;
  logic       in_acc, out_pop;

  assign c               = s_axis_tdata_i;
  assign s_axis_tready_o = (cnt_q <= 3'd2);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign m_axis_tvalid_o = (cnt_q != 3'd0);
  assign out_pop         = m_axis_tvalid_o && m_axis_tready_i;

  // Per-byte lexer step
  always_comb begin
    logic       do_start;
    logic [4:0] sk;
    logic [2:0] p;
    logic       ok;
    logic [2:0] idx_n;
    logic [2:0] hex_n;
    logic [3:0] k_kind;
    logic [2:0] k_err;

    mode_d     = mode_q;
    phase_d    = phase_q;
    which_d    = which_q;
    kidx_d     = kidx_q;
    esc_d      = esc_q;
    hex_d      = hex_q;
    cur_line_d = cur_line_q;
    cur_col_d  = cur_col_q;
    tok_line_d = tok_line_q;
    tok_col_d  = tok_col_q;
    rec        = '0;
    n_rec      = 2'd0;
    do_start   = 1'b0;
    sk         = struct_kind(c);
    p          = phase_q;
    ok         = 1'b1;
    idx_n      = kidx_q + 3'd1;
    hex_n      = hex_q + 3'd1;
    k_kind     = KIND_END;
    k_err      = ERR_OK;

    case (mode_q)
      MODE_STRING: begin
        if (esc_q) begin
          esc_d = 1'b0;
          if (c == "b" || c == "f" || c == "n" || c == "r" || c == "t") begin
            rec[0] = mk_rec(KIND_STRING, 1'b1, "\\", 1'b0, tok_line_q, tok_col_q, ERR_OK);
            rec[1] = mk_rec(KIND_STRING, 1'b1, c, 1'b0, tok_line_q, tok_col_q, ERR_OK);
            n_rec  = 2'd2;
          end else if (c == "\"" || c == "\\" || c == "/") begin
            rec[0] = mk_rec(KIND_STRING, 1'b1, c, 1'b0, tok_line_q, tok_col_q, ERR_OK);
            n_rec  = 2'd1;
          end else if (c == "u") begin
            mode_d = MODE_HEX;
            hex_d  = 3'd0;
          end else begin
            rec[0] = mk_rec(KIND_STRING, 1'b0, 8'd0, 1'b1, tok_line_q, tok_col_q, ERR_ESCAPE);
            n_rec  = 2'd1;
            mode_d = MODE_IDLE;
          end
        end else if (c == "\"") begin
          rec[0] = mk_rec(KIND_STRING, 1'b0, 8'd0, 1'b1, tok_line_q, tok_col_q, ERR_OK);
          n_rec  = 2'd1;
          mode_d = MODE_IDLE;
        end else if (c == "\\") begin
          esc_d = 1'b1;
        end else begin
          rec[0] = mk_rec(KIND_STRING, 1'b1, c, 1'b0, tok_line_q, tok_col_q, ERR_OK);
          n_rec  = 2'd1;
        end
      end
      MODE_HEX: begin
        if (is_hex(c)) begin
          rec[0] = mk_rec(KIND_STRING, 1'b1, c, 1'b0, tok_line_q, tok_col_q, ERR_OK);
          n_rec  = 2'd1;
          if (hex_n >= HEX_DIGITS) begin
            mode_d = MODE_STRING;
            hex_d  = 3'd0;
          end else begin
            hex_d = hex_n;
          end
        end else begin
          rec[0] = mk_rec(KIND_STRING, 1'b0, 8'd0, 1'b1, tok_line_q, tok_col_q, ERR_HEX);
          n_rec  = 2'd1;
          mode_d = MODE_IDLE;
        end
      end
      MODE_NUMBER: begin
        if (is_space(c) || sk[4]) begin
          // delimiter closes the number and is then lexed afresh
          rec[0]   = mk_rec(KIND_NUMBER, 1'b0, 8'd0, 1'b1, tok_line_q, tok_col_q,
                            number_complete(phase_q) ? ERR_OK : ERR_NUMBER);
          n_rec    = 2'd1;
          do_start = 1'b1;
        end else begin
          if (is_digit(c)) begin
            if (p == PH_SIGN) p = PH_INT;
            else if (p == PH_POINT) p = PH_FRAC;
            else if (p == PH_EXP || p == PH_EXPSIGN) p = PH_EXPDIG;
          end else if (c == "." && p == PH_INT) begin
            p = PH_POINT;
          end else if ((c == "e" || c == "E") && (p == PH_INT || p == PH_FRAC)) begin
            p = PH_EXP;
          end else if ((c == "+" || c == "-") && p == PH_EXP) begin
            p = PH_EXPSIGN;
          end else begin
            ok = 1'b0;
          end
          if (ok) begin
            phase_d = p;
            rec[0]  = mk_rec(KIND_NUMBER, 1'b1, c, 1'b0, tok_line_q, tok_col_q, ERR_OK);
          end else begin
            rec[0]  = mk_rec(KIND_NUMBER, 1'b0, 8'd0, 1'b1, tok_line_q, tok_col_q, ERR_NUMBER);
            mode_d  = MODE_IDLE;
          end
          n_rec = 2'd1;
        end
      end
      MODE_KEYWORD: begin
        if ((kidx_q < kw_len(which_q)) && (c == kw_char(which_q, kidx_q))) begin
          kidx_d = idx_n;
          rec[0] = mk_rec(kw_kind(which_q), 1'b1, c, idx_n >= kw_len(which_q),
                          tok_line_q, tok_col_q, ERR_OK);
          if (idx_n >= kw_len(which_q)) mode_d = MODE_IDLE;
        end else begin
          rec[0] = mk_rec(kw_kind(which_q), 1'b0, 8'd0, 1'b1, tok_line_q, tok_col_q,
                          ERR_KEYWORD);
          mode_d = MODE_IDLE;
        end
        n_rec = 2'd1;
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // Token start from idle, or on the delimiter that closes a number
    if (do_start) begin
      tok_line_d = cur_line_q;
      tok_col_d  = cur_col_q;
      mode_d     = MODE_IDLE;
      if (is_space(c)) begin
        mode_d = MODE_IDLE;
      end else if (sk[4]) begin
        rec[n_rec[0]] = mk_rec(sk[3:0], 1'b1, c, 1'b1, cur_line_q, cur_col_q, ERR_OK);
        n_rec         = n_rec + 2'd1;
      end else if (c == "\"") begin
        mode_d = MODE_STRING;
        esc_d  = 1'b0;
        hex_d  = 3'd0;
      end else if (c == "t" || c == "f" || c == "n") begin
        mode_d  = MODE_KEYWORD;
        which_d = (c == "t") ? KW_TRUE : ((c == "f") ? KW_FALSE : KW_NULL);
        kidx_d  = 3'd1;
        rec[n_rec[0]] = mk_rec(kw_kind(which_d), 1'b1, c, 1'b0, cur_line_q, cur_col_q,
                               ERR_OK);
        n_rec   = n_rec + 2'd1;
      end else if (c == "+" || c == "-" || is_digit(c)) begin
        mode_d  = MODE_NUMBER;
        phase_d = is_digit(c) ? PH_INT : PH_SIGN;
        rec[n_rec[0]] = mk_rec(KIND_NUMBER, 1'b1, c, 1'b0, cur_line_q, cur_col_q, ERR_OK);
        n_rec   = n_rec + 2'd1;
      end else begin
        rec[n_rec[0]] = mk_rec(KIND_END, 1'b1, c, 1'b1, cur_line_q, cur_col_q, ERR_START);
        n_rec         = n_rec + 2'd1;
      end
    end

    // Position, saturating
    if (c == 8'h0A) begin
      if (cur_line_q < LINE_MAX) cur_line_d = cur_line_q + LINE_ONE;
      cur_col_d = COL_ONE;
    end else if (cur_col_q < COL_MAX) begin
      cur_col_d = cur_col_q + COL_ONE;
    end

    // End of text: close the open token, mark the end, back to reset state
    if (s_axis_tlast_i) begin
      if (mode_d != MODE_IDLE) begin
        if (mode_d == MODE_STRING) begin
          k_kind = KIND_STRING;
          k_err  = esc_d ? ERR_DANGLING : ERR_UNTERM;
        end else if (mode_d == MODE_HEX) begin
          k_kind = KIND_STRING;
          k_err  = ERR_HEX;
        end else if (mode_d == MODE_NUMBER) begin
          k_kind = KIND_NUMBER;
          k_err  = number_complete(phase_d) ? ERR_OK : ERR_NUMBER;
        end else begin
          k_kind = kw_kind(which_d);
          k_err  = ERR_KEYWORD;
        end
        if (n_rec != 2'd0 && !rec[n_rec[1]].te) begin
          rec[n_rec[1]].te  = 1'b1;
          rec[n_rec[1]].err = k_err;
        end else if (n_rec < 2'd2) begin
          rec[n_rec[0]] = mk_rec(k_kind, 1'b0, 8'd0, 1'b1, tok_line_d, tok_col_d, k_err);
          n_rec         = n_rec + 2'd1;
        end
      end
      if (n_rec < 2'd2) begin
        rec[n_rec[0]] = mk_rec(KIND_END, 1'b0, 8'd0, 1'b1, cur_line_d, cur_col_d, ERR_OK);
        n_rec         = n_rec + 2'd1;
      end
      mode_d     = MODE_IDLE;
      phase_d    = PH_SIGN;
      which_d    = 2'd0;
      kidx_d     = 3'd0;
      esc_d      = 1'b0;
      hex_d      = 3'd0;
      cur_line_d = LINE_ONE;
      cur_col_d  = COL_ONE;
      tok_line_d = LINE_ONE;
      tok_col_d  = COL_ONE;
    end
  end

  // Output queue: shift out at the head, append new records behind
  always_comb begin
    logic [2:0] base;
    base = cnt_q - {2'd0, out_pop};
    for (int i = 0; i < DEPTH - 1; i++) begin
      q_d[i] = out_pop ? q_q[i+1] : q_q[i];
    end
    q_d[DEPTH-1] = q_q[DEPTH-1];
    if (in_acc) begin
      for (int i = 0; i < DEPTH; i++) begin
        if (n_rec != 2'd0 && 3'(i) == base) q_d[i] = rec[0];
        if (n_rec == 2'd2 && 3'(i) == base + 3'd1) q_d[i] = rec[1];
      end
    end
    cnt_d = base + (in_acc ? {1'b0, n_rec} : 3'd0);
  end

  // Lexer state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= MODE_IDLE;
      phase_q    <= PH_SIGN;
      which_q    <= 2'd0;
      kidx_q     <= 3'd0;
      esc_q      <= 1'b0;
      hex_q      <= 3'd0;
      cur_line_q <= LINE_ONE;
      cur_col_q  <= COL_ONE;
      tok_line_q <= LINE_ONE;
      tok_col_q  <= COL_ONE;
      cnt_q      <= 3'd0;
    end else begin
      if (in_acc) begin
        mode_q     <= mode_d;
        phase_q    <= phase_d;
        which_q    <= which_d;
        kidx_q     <= kidx_d;
        esc_q      <= esc_d;
        hex_q      <= hex_d;
        cur_line_q <= cur_line_d;
        cur_col_q  <= cur_col_d;
        tok_line_q <= tok_line_d;
        tok_col_q  <= tok_col_d;
      end
      cnt_q <= cnt_d;
    end
  end

  // Queue payload, no reset needed
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      q_q[i] <= q_d[i];
    end
  end

  // Head record onto the master side
  assign m_axis_tdata_o = OUT_W'({q_q[0].err, q_q[0].col, q_q[0].line, q_q[0].cbyte});
  assign m_axis_tuser_o = {q_q[0].cv, q_q[0].kind};
  assign m_axis_tlast_o = q_q[0].te;

  // Checks
  `JBT_ASSERT(a_cnt_bound, cnt_q <= 3'(DEPTH), "output queue overfilled")
  `JBT_ASSERT(a_last_gives_rec, in_acc && s_axis_tlast_i |-> n_rec != 2'd0,
              "final byte gave no record")
  `JBT_ASSERT(a_last_resets, in_acc && s_axis_tlast_i |=>
              mode_q == MODE_IDLE && cur_line_q == LINE_ONE && cur_col_q == COL_ONE,
              "lexer not back at reset state after final byte")
  `JBT_ASSERT(a_err_on_end, m_axis_tvalid_o |-> (q_q[0].err == ERR_OK || q_q[0].te),
              "error code on a record that ends no token")

endmodule
